[src/scvr_pkg.sv]
// Shared types and constants for the sigma-clipped value range core.
package scvr_pkg;

    localparam int DIV_W   = 64;
    localparam int ACC_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int VAR_W   = 48;
    localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

    typedef struct packed {
        logic load_en;
        logic mean_start;
        logic mean_take;
        logic pass_start;
        logic clip_mode;
        logic var_start;
        logic var_take;
        logic sigma_take;
        logic emit;
    } scvr_cmd_t;

    typedef struct packed {
        logic last_accept;
        logic div_done;
        logic sqrt_done;
        logic pass_done;
        logic pass_busy;
        logic out_free;
    } scvr_stat_t;

endpackage

[src/scvr_div.sv]
// Restoring divider, one quotient bit per cycle.
module scvr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [scvr_pkg::DIV_W-1:0]  dividend,
    input  logic [scvr_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [scvr_pkg::DIV_W-1:0]  quotient,
    output logic [scvr_pkg::DIV_W-1:0]  remainder
);
    localparam int CNT_W = $clog2(scvr_pkg::DIV_W);

    logic [scvr_pkg::DIV_W-1:0] q_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg, done_reg;
    logic [scvr_pkg::DIV_W:0]   rem_sh, rem_nx;
    logic                       ge;

    always_comb begin
        rem_sh = {rem_reg, q_reg[scvr_pkg::DIV_W-1]};
        ge     = rem_sh >= {1'b0, dvs_reg};
        rem_nx = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_nx[scvr_pkg::DIV_W-1:0];
                q_reg   <= {q_reg[scvr_pkg::DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(scvr_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;
endmodule

[src/scvr_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module scvr_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [2*scvr_pkg::ROOT_W-1:0] radicand,
    output logic                         done,
    output logic [scvr_pkg::ROOT_W-1:0]  root
);
    localparam int RW    = scvr_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);

    logic [2*RW-1:0]  rad_reg;
    logic [RW-1:0]    root_reg;
    logic [RW+1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [RW+3:0]    rem_sh, trial, rem_nx;
    logic             ge;

    always_comb begin
        rem_sh = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = rem_sh >= trial;
        rem_nx = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
                rem_reg  <= rem_nx[RW+1:0];
                root_reg <= {root_reg[RW-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

[src/scvr_ctrl.sv]
// Sequencing state machine: load, mean, deviation pass, variance, root, clip pass, emit.
module scvr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scvr_pkg::scvr_stat_t stat,
    output scvr_pkg::scvr_cmd_t  cmd
);
    typedef enum logic [7:0] {
        ST_LOAD      = 8'b0000_0001,
        ST_MEAN_GO   = 8'b0000_0010,
        ST_MEAN_WAIT = 8'b0000_0100,
        ST_DEV       = 8'b0000_1000,
        ST_VAR_WAIT  = 8'b0001_0000,
        ST_SQRT_WAIT = 8'b0010_0000,
        ST_CLIP      = 8'b0100_0000,
        ST_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                if (stat.last_accept) state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                cmd.mean_start = 1'b1;
                state_next     = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (stat.div_done) begin
                    cmd.mean_take  = 1'b1;
                    cmd.pass_start = 1'b1;
                    state_next     = ST_DEV;
                end
            end
            ST_DEV: begin
                if (stat.pass_done) begin
                    cmd.var_start = 1'b1;
                    state_next    = ST_VAR_WAIT;
                end
            end
            ST_VAR_WAIT: begin
                if (stat.div_done) begin
                    cmd.var_take = 1'b1;
                    state_next   = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT: begin
                if (stat.sqrt_done) begin
                    cmd.sigma_take = 1'b1;
                    cmd.pass_start = 1'b1;
                    cmd.clip_mode  = 1'b1;
                    state_next     = ST_CLIP;
                end
            end
            ST_CLIP: begin
                if (stat.pass_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_LOAD;
        else          state_reg <= state_next;
    end
endmodule

[src/scvr_datapath.sv]
// Sample store, accumulators, scan pipeline, divider and root units, output register.
module scvr_datapath #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scvr_pkg::scvr_cmd_t  cmd,
    output scvr_pkg::scvr_stat_t stat,
    input  logic                 s_valid,
    input  logic signed [31:0]   s_sample,
    input  logic                 s_last,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic signed [31:0]   m_low,
    output logic signed [31:0]   m_high,
    output logic                 m_full,
    output logic                 m_wide
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = 32 + AW + 1;
    localparam int DW = scvr_pkg::DIV_W;
    localparam int VW = scvr_pkg::VAR_W;

    logic signed [31:0] mem [MAX_SAMPLES];

    logic                 s_accept, store_ok;
    logic [CW-1:0]        count_reg;
    logic signed [SW-1:0] sum_reg;

    assign s_accept = s_valid & cmd.load_en;
    assign store_ok = count_reg < CW'(MAX_SAMPLES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.emit) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (s_accept && store_ok) begin
            count_reg <= count_reg + 1'b1;
            sum_reg   <= sum_reg + SW'(s_sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && store_ok) mem[count_reg[AW-1:0]] <= s_sample;
    end

    // shared divider: mean from |sum|, variance from the accumulated squared deviations
    localparam int ACC_W_L = scvr_pkg::ACC_W;
    logic          sum_neg;
    logic [SW-1:0] sum_mag;
    logic [DW-1:0] div_dividend, div_divisor, div_q, div_r;
    logic          div_done;
    logic [ACC_W_L-1:0] acc_reg;

    assign sum_neg      = sum_reg[SW-1];
    assign sum_mag      = sum_neg ? SW'(-sum_reg) : SW'(sum_reg);
    assign div_dividend = cmd.var_start ? DW'(acc_reg) : DW'(sum_mag);
    assign div_divisor  = DW'(count_reg);

    scvr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mean_start | cmd.var_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // floor for negative sums: -(q + (r != 0))
    logic [33:0]        mean_mag;
    logic [33:0]        mean_full;
    logic signed [31:0] mean_reg;

    assign mean_mag  = 34'(div_q[32:0]) + 34'(sum_neg && (div_r != '0));
    assign mean_full = sum_neg ? -mean_mag : mean_mag;

    always_ff @(posedge aclk) begin
        if (cmd.mean_take) mean_reg <= mean_full[31:0];
    end

    logic [VW-1:0]                   var_clamp;
    logic                            sqrt_done;
    logic [scvr_pkg::ROOT_W-1:0]     sigma;

    assign var_clamp = (div_q[DW-1:VW] != '0) ? {VW{1'b1}} : div_q[VW-1:0];

    scvr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.var_take),
        .radicand ({var_clamp, 16'h0000}),
        .done     (sqrt_done),
        .root     (sigma)
    );

    logic [33:0]        three_sig;
    logic signed [35:0] lo_reg, hi_reg;

    assign three_sig = {2'b00, sigma} + {1'b0, sigma, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.sigma_take) begin
            lo_reg <= 36'(mean_reg) - $signed({2'b00, three_sig});
            hi_reg <= 36'(mean_reg) + $signed({2'b00, three_sig});
        end
    end

    // scan pipeline: issue -> read -> |d| or clip -> square -> accumulate
    logic [CW-1:0]      iss_cnt_reg;
    logic               iss_act_reg, v0_reg, v1_reg, v2_reg, busy_reg, clip_reg, first_reg;
    logic signed [31:0] rd_data_reg;
    logic [32:0]        absd_reg;
    logic [65:0]        prod_reg;
    logic signed [32:0] diff;
    logic               pass_done;
    logic [ACC_W_L:0]   acc_sum;

    assign diff      = 33'(rd_data_reg) - 33'(mean_reg);
    assign pass_done = busy_reg & ~iss_act_reg & ~v0_reg & ~v1_reg & ~v2_reg;
    assign acc_sum   = {1'b0, acc_reg} + (ACC_W_L + 1)'(prod_reg[65:16]);

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[iss_cnt_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_act_reg <= 1'b0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            busy_reg    <= 1'b0;
            clip_reg    <= 1'b0;
            iss_cnt_reg <= '0;
        end else begin
            v0_reg <= iss_act_reg;
            v1_reg <= v0_reg & ~clip_reg;
            v2_reg <= v1_reg;
            if (cmd.pass_start) begin
                iss_cnt_reg <= '0;
                iss_act_reg <= 1'b1;
                busy_reg    <= 1'b1;
                clip_reg    <= cmd.clip_mode;
            end else begin
                if (iss_act_reg) begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    if (iss_cnt_reg == count_reg - 1'b1) iss_act_reg <= 1'b0;
                end
                if (pass_done) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        absd_reg <= diff[32] ? 33'(-diff) : 33'(diff);
        prod_reg <= 66'(absd_reg) * 66'(absd_reg);
        if (cmd.pass_start && !cmd.clip_mode) acc_reg <= '0;
        else if (v2_reg) acc_reg <= acc_sum[ACC_W_L] ? {ACC_W_L{1'b1}} : acc_sum[ACC_W_L-1:0];
    end

    logic signed [31:0] full_lo_reg, full_hi_reg, in_lo_reg, in_hi_reg;
    logic               inlier_seen_reg, inlier;

    assign inlier = (36'(rd_data_reg) >= lo_reg) && (36'(rd_data_reg) <= hi_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inlier_seen_reg <= 1'b0;
            first_reg       <= 1'b0;
        end else if (cmd.pass_start) begin
            inlier_seen_reg <= 1'b0;
            first_reg       <= 1'b1;
        end else if (v0_reg && clip_reg) begin
            first_reg <= 1'b0;
            if (first_reg) begin
                full_lo_reg <= rd_data_reg;
                full_hi_reg <= rd_data_reg;
            end else begin
                if (rd_data_reg < full_lo_reg) full_lo_reg <= rd_data_reg;
                if (rd_data_reg > full_hi_reg) full_hi_reg <= rd_data_reg;
            end
            if (inlier) begin
                inlier_seen_reg <= 1'b1;
                if (!inlier_seen_reg) begin
                    in_lo_reg <= rd_data_reg;
                    in_hi_reg <= rd_data_reg;
                end else begin
                    if (rd_data_reg < in_lo_reg) in_lo_reg <= rd_data_reg;
                    if (rd_data_reg > in_hi_reg) in_hi_reg <= rd_data_reg;
                end
            end
        end
    end

    // result stage with widening of equal ends by one unit, saturating
    logic signed [31:0] sel_lo, sel_hi;
    logic signed [32:0] lo_w, hi_w;
    logic               same;
    logic signed [31:0] out_lo_next, out_hi_next;
    logic               m_valid_reg, out_full_reg, out_wide_reg;
    logic signed [31:0] out_lo_reg, out_hi_reg;

    always_comb begin
        sel_lo = inlier_seen_reg ? in_lo_reg : full_lo_reg;
        sel_hi = inlier_seen_reg ? in_hi_reg : full_hi_reg;
        same   = sel_lo == sel_hi;
        lo_w   = 33'(sel_lo) - scvr_pkg::ONE_Q16;
        hi_w   = 33'(sel_hi) + scvr_pkg::ONE_Q16;
        out_lo_next = sel_lo;
        out_hi_next = sel_hi;
        if (same) begin
            out_lo_next = (lo_w[32] != lo_w[31]) ? 32'sh8000_0000 : lo_w[31:0];
            out_hi_next = (hi_w[32] != hi_w[31]) ? 32'sh7FFF_FFFF : hi_w[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_lo_reg   <= out_lo_next;
            out_hi_reg   <= out_hi_next;
            out_full_reg <= ~inlier_seen_reg;
            out_wide_reg <= same;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_low   = out_lo_reg;
    assign m_high  = out_hi_reg;
    assign m_full  = out_full_reg;
    assign m_wide  = out_wide_reg;

    always_comb begin
        stat             = '0;
        stat.last_accept = s_accept & s_last;
        stat.div_done    = div_done;
        stat.sqrt_done   = sqrt_done;
        stat.pass_done   = pass_done;
        stat.pass_busy   = busy_reg;
        stat.out_free    = ~m_valid_reg | m_ready;
    end
endmodule

[src/sigma_clipped_value_range_core.sv]
// Sigma-clipped value range core: streams in a set of signed Q16.16 samples (tlast on the
// final one), one per cycle, into an internal store of MAX_SAMPLES entries; samples beyond
// that are dropped but tlast still closes the set. After the last sample it computes the
// floor mean, the population variance and sigma, then the min/max of samples within
// mean +/- 3 sigma (or of all samples if none lie inside), widening equal ends by 1.0 with
// saturation. Processing uses the shared divider (used twice, for the mean and the
// variance), the square root unit and two scans of the store at one read per cycle.
// Input is not taken during processing; a finished result may wait in the output
// register while the next set loads.
module sigma_clipped_value_range_core #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] range_low, [63:32] range_high
    output logic [1:0]  m_tuser    // [0] used_full_range, [1] was_widened
);
    scvr_pkg::scvr_cmd_t  cmd;
    scvr_pkg::scvr_stat_t stat;
    logic signed [31:0]   low, high;
    logic                 full, wide;

    scvr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    scvr_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_valid  (s_tvalid),
        .s_sample (s_tdata),
        .s_last   (s_tlast),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_low    (low),
        .m_high   (high),
        .m_full   (full),
        .m_wide   (wide)
    );

    assign s_tready = cmd.load_en;
    assign m_tdata  = {high, low};
    assign m_tuser  = {wide, full};

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over an untaken transaction");
    a_no_load_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pass_busy |-> !s_tready)
        else $error("input taken during a store scan");
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.div_done && stat.sqrt_done))
        else $error("divider and root finished together");
    a_pass_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_start |=> stat.pass_busy)
        else $error("scan did not start");
`endif
endmodule
